// ===== rtl/pai_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// permutation table block. Depends on nothing.
package pai_pkg;

  localparam int ELEMENTS    = 16;
  localparam int IDX_W       = $clog2(ELEMENTS);
  localparam int DATA_W      = 4;
  localparam int COUNT_W     = 12;
  localparam int ORDER_LIMIT = 4095;
  localparam int COUNT_MAX   = 4095;
  localparam logic [COUNT_W-1:0] ORDER_CAP =
    COUNT_W'((ORDER_LIMIT < COUNT_MAX) ? ORDER_LIMIT : COUNT_MAX);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_APPLY  = 2'd1;
  localparam logic [1:0] OP_INVERT = 2'd2;
  localparam logic [1:0] OP_ORDER  = 2'd3;

  // Table pass kinds run by the datapath sweep engine.
  localparam logic [1:0] PASS_INIT    = 2'd0; // power <= map
  localparam logic [1:0] PASS_COMPOSE = 2'd1; // power[i] <= map[power[i]]
  localparam logic [1:0] PASS_SCAN    = 2'd2; // first preimage into power
  localparam logic [1:0] PASS_COPY    = 2'd3; // inverse back into map

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       pass_start;
    logic [1:0] kind;
    logic       count_init;
    logic       count_inc;
    logic       res_clr;
    logic       res_image;
    logic       res_order;
    logic       res_fail;
    logic       out_push;
  } pai_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] kind;
    logic       pass_done;
    logic       ident;
    logic       at_limit;
    logic       out_free;
  } pai_sts_t;

endpackage

// ===== rtl/pai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pai_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pai_ctrl.sv =====
// Sequencing state machine for the permutation table block.
// Depends on pai_pkg for op codes, pass kinds and command/status types.
module pai_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pai_pkg::pai_sts_t sts,
  output pai_pkg::pai_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_PASS   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_clr = 1'b1;
        unique case (sts.op)
          pai_pkg::OP_LOAD: begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_RESULT;
          end
          pai_pkg::OP_APPLY: begin
            state_nxt = S_APPLY;
          end
          pai_pkg::OP_INVERT: begin
            cmd.pass_start = 1'b1;
            cmd.kind       = pai_pkg::PASS_SCAN;
            state_nxt      = S_PASS;
          end
          default: begin
            cmd.pass_start = 1'b1;
            cmd.kind       = pai_pkg::PASS_INIT;
            cmd.count_init = 1'b1;
            state_nxt      = S_PASS;
          end
        endcase
      end
      S_APPLY: begin
        cmd.res_image = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_PASS: begin
        if (sts.pass_done) begin
          case (sts.kind)
            pai_pkg::PASS_SCAN: begin
              cmd.pass_start = 1'b1;
              cmd.kind       = pai_pkg::PASS_COPY;
            end
            pai_pkg::PASS_COPY: state_nxt = S_RESULT;
            default:            state_nxt = S_CHECK;
          endcase
        end
      end
      S_CHECK: begin
        if (sts.ident) begin
          cmd.res_order = 1'b1;
          state_nxt     = S_RESULT;
        end else if (sts.at_limit) begin
          cmd.res_order = 1'b1;
          cmd.res_fail  = 1'b1;
          state_nxt     = S_RESULT;
        end else begin
          cmd.pass_start = 1'b1;
          cmd.kind       = pai_pkg::PASS_COMPOSE;
          cmd.count_inc  = 1'b1;
          state_nxt      = S_PASS;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_push_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_push |-> (state_r == S_RESULT) && sts.out_free)
    else $error("result pushed outside result state or into a full register");
  a_check_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> $past(state_r) == S_PASS)
    else $error("order check entered without a finished pass");
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_EXEC)
    else $error("captured item not executed");

endmodule

// ===== rtl/pai_dp.sv =====
// Datapath: map and power tables, three-stage sweep engine, order counter,
// result and output registers. Depends on pai_pkg and pai_ram.
module pai_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pai_pkg::pai_cmd_t              cmd,
  output pai_pkg::pai_sts_t              sts,
  input  logic [1:0]                     in_op,
  input  logic [pai_pkg::IDX_W-1:0]      in_key,
  input  logic [pai_pkg::DATA_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pai_pkg::DATA_W-1:0]     out_image,
  output logic [pai_pkg::COUNT_W-1:0]    out_order_count,
  output logic                           out_status
);

  logic [1:0]                      op_r;
  logic [pai_pkg::IDX_W-1:0]       key_r;
  logic [pai_pkg::DATA_W-1:0]      value_r;

  // sweep engine
  logic [1:0]                      kind_r;
  logic                            run_r, v1_r, v2_r;
  logic [pai_pkg::IDX_W-1:0]       iss_r, idx1_r, idx2_r;
  logic                            ident_r;
  logic [pai_pkg::ELEMENTS-1:0]    seen_r;
  logic                            pass_done;

  logic [pai_pkg::COUNT_W-1:0]     count_r;

  logic [pai_pkg::DATA_W-1:0]      res_image_r;
  logic [pai_pkg::COUNT_W-1:0]     res_order_r;
  logic                            res_status_r;
  logic                            out_valid_r;
  logic [pai_pkg::DATA_W-1:0]      out_image_r;
  logic [pai_pkg::COUNT_W-1:0]     out_order_r;
  logic                            out_status_r;

  // map table with per-entry valid bits; unwritten entries read as identity
  logic [pai_pkg::ELEMENTS-1:0]    mv_r;
  logic                            mv_q_r;
  logic [pai_pkg::IDX_W-1:0]       maddr_q_r;
  logic                            m_we;
  logic [pai_pkg::IDX_W-1:0]       m_waddr, m_raddr;
  logic [pai_pkg::DATA_W-1:0]      m_wdata, m_ram_rdata, map_rdata;

  logic                            p_we;
  logic [pai_pkg::IDX_W-1:0]       p_waddr;
  logic [pai_pkg::DATA_W-1:0]      p_wdata, power_rdata;

  logic                            pow_kind;

  assign pow_kind  = (kind_r == pai_pkg::PASS_INIT) || (kind_r == pai_pkg::PASS_COMPOSE);
  assign map_rdata = mv_q_r ? m_ram_rdata : maddr_q_r;
  assign pass_done = v2_r && (idx2_r == pai_pkg::LAST_IDX);

  always_comb begin
    if (v1_r) begin
      m_raddr = (kind_r == pai_pkg::PASS_COMPOSE) ? power_rdata[pai_pkg::IDX_W-1:0] : idx1_r;
    end else begin
      m_raddr = key_r;
    end
    m_we    = 1'b0;
    m_waddr = key_r;
    m_wdata = value_r;
    if (cmd.load_wr) begin
      m_we = 1'b1;
    end else if (v1_r && (kind_r == pai_pkg::PASS_COPY)) begin
      m_we    = 1'b1;
      m_waddr = idx1_r;
      m_wdata = seen_r[idx1_r] ? power_rdata : idx1_r;
    end
  end

  always_comb begin
    p_we    = 1'b0;
    p_waddr = idx2_r;
    p_wdata = map_rdata;
    if (v2_r && pow_kind) begin
      p_we = 1'b1;
    end else if (v2_r && (kind_r == pai_pkg::PASS_SCAN) && !seen_r[map_rdata]) begin
      p_we    = 1'b1;
      p_waddr = map_rdata;
      p_wdata = idx2_r;
    end
  end

  pai_ram #(.WIDTH(pai_pkg::DATA_W), .DEPTH(pai_pkg::ELEMENTS)) u_map_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_ram_rdata)
  );

  pai_ram #(.WIDTH(pai_pkg::DATA_W), .DEPTH(pai_pkg::ELEMENTS)) u_power_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (iss_r),
    .rdata (power_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      key_r   <= in_key;
      value_r <= in_value;
    end
    maddr_q_r <= m_raddr;
    mv_q_r    <= mv_r[m_raddr];
    if (cmd.pass_start) begin
      kind_r <= cmd.kind;
    end
    idx1_r <= iss_r;
    idx2_r <= idx1_r;
    if (cmd.count_init) begin
      count_r <= pai_pkg::COUNT_W'(1);
    end else if (cmd.count_inc) begin
      count_r <= count_r + pai_pkg::COUNT_W'(1);
    end
    if (cmd.res_clr) begin
      res_image_r  <= '0;
      res_order_r  <= '0;
      res_status_r <= 1'b0;
    end else if (cmd.res_image) begin
      res_image_r <= map_rdata;
    end else if (cmd.res_order) begin
      res_order_r  <= count_r;
      res_status_r <= cmd.res_fail;
    end
    if (cmd.out_push) begin
      out_image_r  <= res_image_r;
      out_order_r  <= res_order_r;
      out_status_r <= res_status_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      iss_r       <= '0;
      ident_r     <= 1'b1;
      seen_r      <= '0;
      mv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= run_r;
      v2_r <= v1_r;
      if (cmd.pass_start) begin
        run_r   <= 1'b1;
        iss_r   <= '0;
        ident_r <= 1'b1;
        if (cmd.kind == pai_pkg::PASS_SCAN) begin
          seen_r <= '0;
        end
      end else if (run_r) begin
        iss_r <= iss_r + pai_pkg::IDX_W'(1);
        if (iss_r == pai_pkg::LAST_IDX) begin
          run_r <= 1'b0;
        end
      end
      if (v2_r && pow_kind && (map_rdata != idx2_r)) begin
        ident_r <= 1'b0;
      end
      if (v2_r && (kind_r == pai_pkg::PASS_SCAN)) begin
        seen_r[map_rdata] <= 1'b1;
      end
      if (m_we) begin
        mv_r[m_waddr] <= 1'b1;
      end
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.kind      = kind_r;
  assign sts.pass_done = pass_done;
  assign sts.ident     = ident_r;
  assign sts.at_limit  = (count_r == pai_pkg::ORDER_CAP);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_image       = out_image_r;
  assign out_order_count = out_order_r;
  assign out_status      = out_status_r;

  a_run_feeds_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |=> v1_r)
    else $error("issued element lost in sweep pipeline");
  a_done_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    pass_done |-> !run_r)
    else $error("pass finished while still issuing");
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_start |-> !run_r && !v1_r)
    else $error("pass started over a running pass");

endmodule

// ===== rtl/permutation_apply_invert_order.sv =====
// Permutation table block: load, apply, in-place invert and order by repeated
// composition. Top level; depends on pai_pkg, pai_ctrl, pai_dp (and pai_ram).
//
// One item is worked on at a time; in_stall is high from acceptance until the
// result has been moved into the output register, which can still hold the
// previous result while the next item is taken. A load writes the map entry
// and an apply reads one, each then moving its result into the output register.
// Invert runs two table sweeps through the three-stage sweep pipeline over the
// map and power RAMs. Order runs one sweep per power of the map until the
// identity or the limit of 4095 is reached; the single power-table write port
// sets the sweep length. The map resets to the identity through per-entry valid
// bits, so no clearing pass is needed after reset.
module permutation_apply_invert_order (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [pai_pkg::IDX_W-1:0]      in_key,
  input  logic [pai_pkg::DATA_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pai_pkg::DATA_W-1:0]     out_image,
  output logic [pai_pkg::COUNT_W-1:0]    out_order_count,
  output logic                           out_status
);

  pai_pkg::pai_cmd_t cmd;
  pai_pkg::pai_sts_t sts;

  // Sequence ops: decode, run sweeps, check identity or limit, hand off result.
  pai_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the tables, run the sweeps, count powers, drive the output register.
  pai_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_image       (out_image),
    .out_order_count (out_order_count),
    .out_status      (out_status)
  );

endmodule
